>>> design/dedup_fault_log_store_macros.svh
// Assertion macros for the fault log store.
`ifndef DEDUP_FAULT_LOG_STORE_MACROS_SVH
`define DEDUP_FAULT_LOG_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DFLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fault log store: same-cycle check failed");
`define DFLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fault log store: next-cycle check failed");
`else
`define DFLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DFLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/dfls_pkg.sv
`default_nettype none

package dfls_pkg;

	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OUT_PUSHED    = 2'd0,
		OUT_UPDATED   = 2'd1,
		OUT_DROPPED   = 2'd2,
		OUT_MALFORMED = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_OLD    = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	typedef struct packed {
		logic [7:0]  loc;
		logic [7:0]  code;
		logic [31:0] ts;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic old_rd;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic rem_one;
	} ctrl_sts_t;

endpackage

`default_nettype wire

>>> design/dedup_fault_log_store.sv
// Deduplicating fault log. A request is taken when start is high and busy is low; the
// block then reads every stored entry once through its single memory read port, newest
// first, reads the oldest slot, and decides. The result appears on outcome, entry_count
// and slot_touched, flagged by done for exactly one cycle, in the same cycle that busy
// falls; there is no back-pressure, so the receiver must capture it in that cycle.
// priority_timeout is written through cfg_valid, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
`default_nettype none

`include "dedup_fault_log_store_macros.svh"

module dedup_fault_log_store #(
	parameter int DEPTH = dfls_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  error_location,
	input  logic [6:0]  error_code,
	input  logic        priority_req,
	input  logic [31:0] timestamp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] priority_timeout,
	output logic        done,
	output logic [1:0]  outcome,
	output logic [4:0]  entry_count,
	output logic [3:0]  slot_touched
);

	dfls_pkg::ctrl_cmd_t cmd;
	dfls_pkg::ctrl_sts_t sts;
	logic                res_no_slot;

	assign cfg_ready = 1'b1;

	dfls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dfls_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.error_location (error_location),
		.error_code     (error_code),
		.priority_req   (priority_req),
		.timestamp      (timestamp),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_data       (priority_timeout),
		.done           (done),
		.outcome        (outcome),
		.entry_count    (entry_count),
		.slot_touched   (slot_touched)
	);

	assign res_no_slot = done &&
		(outcome inside {dfls_pkg::OUT_DROPPED, dfls_pkg::OUT_MALFORMED});

	`DFLS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`DFLS_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy && $past(busy))
	`DFLS_ASSERT_IMPL(a_no_slot_unwritten, clk, arst_n, res_no_slot, slot_touched == 4'd0)
	`DFLS_ASSERT_NEXT(a_decide_done, clk, arst_n, cmd.commit, done)

endmodule

`default_nettype wire

>>> design/dfls_ctrl.sv
`default_nettype none

module dfls_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dfls_pkg::ctrl_sts_t   sts,
	output dfls_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);

	dfls_pkg::state_t state_q;
	dfls_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dfls_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = dfls_pkg::ST_SCAN;
				end
			end
			dfls_pkg::ST_SCAN: begin
				if (sts.rem_zero || sts.rem_one) begin
					state_nxt = dfls_pkg::ST_OLD;
				end
			end
			dfls_pkg::ST_OLD: begin
				state_nxt = dfls_pkg::ST_DECIDE;
			end
			dfls_pkg::ST_DECIDE: begin
				state_nxt = dfls_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = dfls_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfls_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy        = (state_q != dfls_pkg::ST_IDLE);
	assign cmd.load    = (state_q == dfls_pkg::ST_IDLE) && start;
	assign cmd.scan_rd = (state_q == dfls_pkg::ST_SCAN) && !sts.rem_zero;
	assign cmd.old_rd  = (state_q == dfls_pkg::ST_OLD);
	assign cmd.commit  = (state_q == dfls_pkg::ST_DECIDE);

endmodule

`default_nettype wire

>>> design/dfls_datapath.sv
`default_nettype none

module dfls_datapath #(
	parameter int DEPTH = dfls_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dfls_pkg::ctrl_cmd_t   cmd,
	output dfls_pkg::ctrl_sts_t   sts,
	input  logic [7:0]            error_location,
	input  logic [6:0]            error_code,
	input  logic                  priority_req,
	input  logic [31:0]           timestamp,
	input  logic                  cfg_wr,
	input  logic [31:0]           cfg_data,
	output logic                  done,
	output logic [1:0]            outcome,
	output logic [4:0]            entry_count,
	output logic [3:0]            slot_touched
);

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

	dfls_pkg::entry_t   mem_q [DEPTH];
	dfls_pkg::entry_t   rd_q;
	dfls_pkg::entry_t   ev_q;
	logic [31:0]        tmo_q;
	logic [SW-1:0]      newest_q;
	logic [SW-1:0]      scan_q;
	logic [SW-1:0]      best_slot_q;
	logic [SW-1:0]      cmp_slot_s1;
	logic               cmp_vld_s1;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic [1:0]         match_q;
	logic [31:0]        best_ts_q;
	logic               done_q;
	dfls_pkg::outcome_t outcome_q;
	logic [4:0]         count_out_q;
	logic [3:0]         touched_q;

	logic [SW-1:0]      oldest;
	logic [SW-1:0]      scan_prev;
	logic [SW-1:0]      rd_addr;
	logic               hit;
	logic               full;
	logic [31:0]        age;
	logic               guard;
	logic               wr_en;
	logic [SW-1:0]      wr_addr;
	dfls_pkg::outcome_t outcome_nxt;
	logic [SW-1:0]      res_slot;
	logic               push;
	logic [CW-1:0]      count_nxt;
	logic [SW+3:0]      slot_ext;
	logic [CW+4:0]      count_ext;

	assign oldest    = (newest_q == SLOT_LAST) ? '0 : newest_q + 1'b1;
	assign scan_prev = (scan_q == '0) ? SLOT_LAST : scan_q - 1'b1;
	assign rd_addr   = cmd.old_rd ? oldest : scan_q;
	assign hit       = cmp_vld_s1 && (rd_q.loc == ev_q.loc) && (rd_q.code == ev_q.code);
	assign full      = (count_q == CNT_FULL);
	assign age       = ev_q.ts - rd_q.ts;
	assign guard     = full && rd_q.code[7] && (age < tmo_q);

	assign sts.rem_zero = (rem_q == '0);
	assign sts.rem_one  = (rem_q == CW'(1));

	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = oldest;
		outcome_nxt = dfls_pkg::OUT_MALFORMED;
		res_slot    = '0;
		if (match_q <= 2'd1) begin
			if (!guard) begin
				wr_en       = cmd.commit;
				outcome_nxt = dfls_pkg::OUT_PUSHED;
				res_slot    = oldest;
			end else begin
				outcome_nxt = dfls_pkg::OUT_DROPPED;
			end
		end else if (match_q == 2'd2) begin
			wr_en       = cmd.commit;
			wr_addr     = best_slot_q;
			outcome_nxt = dfls_pkg::OUT_UPDATED;
			res_slot    = best_slot_q;
		end
	end

	assign push      = (outcome_nxt == dfls_pkg::OUT_PUSHED);
	assign count_nxt = (push && !full) ? count_q + 1'b1 : count_q;
	assign slot_ext  = {4'b0, res_slot};
	assign count_ext = {5'b0, count_nxt};

	// matched entries carry the event's location and code, so an update rewrites the whole entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= ev_q;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q      <= '0;
			newest_q   <= '0;
			count_q    <= '0;
			rem_q      <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			match_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
			done_q     <= cmd.commit;
			if (cfg_wr) begin
				tmo_q <= cfg_data;
			end
			if (cmd.load) begin
				match_q <= '0;
				rem_q   <= count_q;
				scan_q  <= newest_q;
			end
			if (cmd.scan_rd) begin
				rem_q  <= rem_q - 1'b1;
				scan_q <= scan_prev;
			end
			if (hit && (match_q != 2'd3)) begin
				match_q <= match_q + 1'b1;
			end
			if (cmd.commit && push) begin
				newest_q <= oldest;
				count_q  <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_q.loc  <= error_location;
			ev_q.code <= {priority_req, error_code};
			ev_q.ts   <= timestamp;
		end
		cmp_slot_s1 <= scan_q;
		// strictly later time wins, so on a tie the newer entry seen first stays
		if (hit && ((match_q == 2'd0) || (rd_q.ts > best_ts_q))) begin
			best_slot_q <= cmp_slot_s1;
			best_ts_q   <= rd_q.ts;
		end
		if (cmd.commit) begin
			outcome_q   <= outcome_nxt;
			count_out_q <= count_ext[4:0];
			touched_q   <= slot_ext[3:0];
		end
	end

	assign done         = done_q;
	assign outcome      = outcome_q;
	assign entry_count  = count_out_q;
	assign slot_touched = touched_q;

endmodule

`default_nettype wire
